// File: src/msb_pkg.sv
// Shared constants and beat types for the merge sort block.
package msb_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int VALUE_W   = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int POS_W     = CNT_W + 2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      last_out;
        logic                      overflow;
    } out_t;

endpackage

// File: src/merge_sort_block_unit.sv
// Merge sort block: collects a set of signed values, sorts it, streams it out.
//
// Values are taken one beat per cycle into buffer A until a beat marked last
// arrives; beats beyond MAX_ITEMS (16) are dropped and flagged as overflow on
// every result of that set. The set of n values is then sorted ascending by
// ceil(log2 n) bottom-up merge passes that move data between two ping-pong
// RAMs through one shared compare unit. Each merged element goes through a
// registered RAM read (S_READ), then a compare and write (S_MERGE), and each
// run begins with a setup state (S_SETUP). The sorted values then leave one
// at a time: each is read, loaded into the output register and held until
// m_ready, the final one marked by last_out. Input is not ready while a set
// is sorted or emitted.
module merge_sort_block_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  msb_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output msb_pkg::out_t  m_data
);

    import msb_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP,
        S_READ,
        S_MERGE,
        S_OUT_READ,
        S_OUT_LOAD,
        S_OUT_WAIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               dropped_reg, dropped_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [POS_W-1:0]   width_reg, width_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               src_b_reg, src_b_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic               in_beat;
    logic               store_ok;
    logic [VALUE_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [VALUE_W-1:0] src_d0, src_d1;
    logic [IDX_W-1:0]   rd0_addr, rd1_addr, wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               merge_we, we_a, we_b;
    logic               left_ok, right_ok, take_left;
    logic [VALUE_W-1:0] merged;
    logic [POS_W-1:0]   mid_sum, hi_sum, lo_step, width_dbl;
    logic [CNT_W-1:0]   k_inc;

    assign s_ready  = (state_reg == S_LOAD);
    assign in_beat  = s_valid && s_ready;
    assign store_ok = (fill_reg < CNT_W'(MAX_ITEMS));

    // Pick the source buffer's read data
    assign src_d0 = src_b_reg ? b_rd0 : a_rd0;
    assign src_d1 = src_b_reg ? b_rd1 : a_rd1;

    // Shared compare unit: ties take the right run
    assign left_ok   = (i_reg < mid_reg);
    assign right_ok  = (j_reg < hi_reg);
    assign take_left = left_ok && (!right_ok || ($signed(src_d0) < $signed(src_d1)));
    assign merged    = take_left ? src_d0 : src_d1;

    // Run bounds and step arithmetic
    assign mid_sum   = POS_W'(lo_reg) + width_reg;
    assign width_dbl = width_reg << 1;
    assign hi_sum    = POS_W'(lo_reg) + width_dbl;
    assign lo_step   = POS_W'(lo_reg) + width_dbl;
    assign k_inc     = k_reg + 1'b1;

    // Steer RAM ports
    assign merge_we = (state_reg == S_MERGE);
    assign we_a     = (in_beat && store_ok) || (merge_we && src_b_reg);
    assign we_b     = merge_we && !src_b_reg;
    assign wr_addr  = merge_we ? k_reg[IDX_W-1:0] : fill_reg[IDX_W-1:0];
    assign wr_data  = merge_we ? merged : s_data.value;
    assign rd0_addr = (state_reg == S_OUT_READ) ? k_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign rd1_addr = j_reg[IDX_W-1:0];

    msb_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_ram_a (
        .aclk     (aclk),
        .wr_en    (we_a),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd0_addr (rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (a_rd0),
        .rd1_data (a_rd1)
    );

    msb_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_ram_b (
        .aclk     (aclk),
        .wr_en    (we_b),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd0_addr (rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (b_rd0),
        .rd1_data (b_rd1)
    );

    // Sequencer: load, merge passes, emit
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        n_next       = n_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        src_b_next   = src_b_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        case (state_reg)
            S_LOAD: begin
                if (in_beat) begin
                    if (store_ok) begin
                        fill_next = fill_reg + 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_data.last) begin
                        n_next     = fill_next;
                        width_next = POS_W'(1);
                        lo_next    = '0;
                        k_next     = '0;
                        src_b_next = 1'b0;
                        state_next = (fill_next > CNT_W'(1)) ? S_SETUP : S_OUT_READ;
                    end
                end
            end
            S_SETUP: begin
                mid_next   = (mid_sum > POS_W'(n_reg)) ? n_reg : mid_sum[CNT_W-1:0];
                hi_next    = (hi_sum > POS_W'(n_reg)) ? n_reg : hi_sum[CNT_W-1:0];
                i_next     = lo_reg;
                j_next     = mid_next;
                k_next     = lo_reg;
                state_next = S_READ;
            end
            S_READ: begin
                state_next = S_MERGE;
            end
            S_MERGE: begin
                if (take_left) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
                k_next     = k_inc;
                state_next = S_READ;
                if (k_inc == hi_reg) begin
                    if (lo_step >= POS_W'(n_reg)) begin
                        // Pass done: swap buffers and double the run length
                        width_next = width_dbl;
                        src_b_next = !src_b_reg;
                        lo_next    = '0;
                        if (width_dbl >= POS_W'(n_reg)) begin
                            k_next     = '0;
                            state_next = S_OUT_READ;
                        end else begin
                            state_next = S_SETUP;
                        end
                    end else begin
                        lo_next    = lo_step[CNT_W-1:0];
                        state_next = S_SETUP;
                    end
                end
            end
            S_OUT_READ: begin
                state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                m_data_next.value_res = src_d0;
                m_data_next.last_out  = (k_inc == n_reg);
                m_data_next.overflow  = dropped_reg;
                m_valid_next          = 1'b1;
                state_next            = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    k_next       = k_inc;
                    if (k_inc == n_reg) begin
                        fill_next    = '0;
                        dropped_next = 1'b0;
                        state_next   = S_LOAD;
                    end else begin
                        state_next = S_OUT_READ;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            src_b_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
            src_b_reg   <= src_b_next;
        end
        n_reg      <= n_next;
        width_reg  <= width_next;
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: src/msb_ram.sv
// Generic RAM: one write port, two registered read ports.
module msb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd0_addr,
    input  logic [$clog2(DEPTH)-1:0] rd1_addr,
    output logic [WIDTH-1:0]         rd0_data,
    output logic [WIDTH-1:0]         rd1_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read two words each cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

// File: bench/tb_merge_sort_block_unit.sv
// Testbench for merge_sort_block_unit: sends value sets, predicts sorted beats, checks them.
`timescale 1ns / 100ps

module tb_merge_sort_block_unit;
    import msb_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int ITEM_TARGET    = 310;
    localparam int DRAIN_CYCLES   = 200;
    localparam int MISMATCH_SHOWN = 10;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_LONG
    } rx_mode_t;

    typedef logic signed [VALUE_W-1:0] value_t;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    // Sorter mirror: values collected for the current set
    value_t      coll_vals [MAX_ITEMS];
    int          coll_count   = 0;
    bit          coll_dropped = 1'b0;
    out_t        sorted_q [$];

    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          stored_items   = 0;
    int          burst_left     = 1;
    int unsigned rx_tick        = 0;
    rx_mode_t    rx_mode        = RX_OPEN;

    merge_sort_block_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Sort the collected set by bottom-up merge passes, ties take the right run
    function automatic void queue_sorted_set();
        value_t src [MAX_ITEMS];
        value_t dst [MAX_ITEMS];
        int     n, w, lo, mid, hi, i, j, k;
        out_t   beat;
        n   = coll_count;
        src = coll_vals;
        dst = coll_vals;
        for (w = 1; w < n; w = w * 2) begin
            for (lo = 0; lo < n; lo = lo + 2 * w) begin
                mid = (lo + w < n) ? lo + w : n;
                hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
                i = lo;
                j = mid;
                for (k = lo; k < hi; k++) begin
                    if (j >= hi || (i < mid && src[i] < src[j])) begin
                        dst[k] = src[i];
                        i++;
                    end else begin
                        dst[k] = src[j];
                        j++;
                    end
                end
            end
            src = dst;
        end
        for (k = 0; k < n; k++) begin
            beat.value_res = src[k];
            beat.last_out  = (k == n - 1);
            beat.overflow  = coll_dropped;
            sorted_q.push_back(beat);
        end
        coll_count   = 0;
        coll_dropped = 1'b0;
    endfunction

    // Store or drop one accepted value; a last beat closes the set
    function automatic void absorb_beat(in_t beat);
        if (coll_count < MAX_ITEMS) begin
            coll_vals[coll_count] = beat.value;
            coll_count++;
        end else begin
            coll_dropped = 1'b1;
        end
        if (beat.last)
            queue_sorted_set();
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOWN)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Compare one result beat with the oldest expected one
    function automatic void check_result(out_t got);
        out_t want;
        if (sorted_q.size() == 0) begin
            note_mismatch($sformatf("unexpected beat value=%0d last=%0b ovf=%0b",
                                    got.value_res, got.last_out, got.overflow));
            return;
        end
        want = sorted_q.pop_front();
        if (got.value_res !== want.value_res)
            note_mismatch($sformatf("value expected %0d got %0d",
                                    want.value_res, got.value_res));
        if (got.last_out !== want.last_out)
            note_mismatch($sformatf("last_out expected %0b got %0b",
                                    want.last_out, got.last_out));
        if (got.overflow !== want.overflow)
            note_mismatch($sformatf("overflow expected %0b got %0b",
                                    want.overflow, got.overflow));
    endfunction

    // Sample both channels at each edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                absorb_beat(s_data);
            if (m_valid && m_ready)
                check_result(m_data);
        end
    end

    // Receiver stall pattern: m_ready follows a mode that is picked anew at random
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 128 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 2) != 0);
            RX_SPARSE: m_ready <= (rx_tick % 4 == 0);
            default:   m_ready <= (rx_tick % 23 == 0);
        endcase
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive one input beat, hold until accepted, then maybe open a gap
    task automatic send_beat(input value_t val, input logic is_last);
        in_t beat;
        int  gap;
        beat.value = val;
        beat.last  = is_last;
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Send a whole set, marking the final value as last
    task automatic send_set(input value_t vals[$]);
        for (int i = 0; i < vals.size(); i++)
            send_beat(vals[i], i == vals.size() - 1);
        stored_items += (vals.size() < MAX_ITEMS) ? vals.size() : MAX_ITEMS;
    endtask

    function automatic value_t pick_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            return value_t'($urandom);
        if (pick <= 8)
            return value_t'($urandom_range(0, 7)) - 4;
        case ($urandom_range(0, 3))
            0:       return {1'b1, {(VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(VALUE_W-1){1'b1}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Extremes and alternating bit patterns, negatives mixed with positives
    task automatic test_extremes();
        value_t vals[$];
        vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1,
                 32'sh5555_5555, 32'shAAAA_AAAA};
        send_set(vals);
    endtask

    // Set of one value: last beat alone
    task automatic test_single_value();
        value_t vals[$];
        vals = '{-32'sd12345};
        send_set(vals);
    endtask

    // Equal keys spread over both runs
    task automatic test_equal_keys();
        value_t vals[$];
        vals = '{32'sd7, -32'sd2, 32'sd7};
        send_set(vals);
    endtask

    // Full store, then the last beat arrives and is dropped
    task automatic test_overflow_set();
        value_t vals[$];
        for (int i = 0; i <= MAX_ITEMS; i++)
            vals.push_back(pick_value());
        send_set(vals);
    endtask

    // Random sets, mostly small, some exactly full, some overflowing
    task automatic test_random_sets();
        value_t      vals[$];
        int          size;
        int unsigned shape;
        while (stored_items < ITEM_TARGET) begin
            shape = $urandom_range(0, 9);
            if (shape <= 5)
                size = $urandom_range(1, 8);
            else if (shape <= 7)
                size = $urandom_range(9, MAX_ITEMS);
            else if (shape == 8)
                size = MAX_ITEMS;
            else
                size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
            vals.delete();
            for (int i = 0; i < size; i++)
                vals.push_back(pick_value());
            send_set(vals);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_single_value();
        test_equal_keys();
        test_overflow_set();
        test_random_sets();
        s_valid <= 1'b0;

        // Let the final beat be sampled before looking at the queue
        @(posedge aclk);

        // Wait out the last sort, then watch for stray beats
        while (sorted_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && sorted_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
